/* sv/framed_word_packet_parser_defines.svh */
// assertion macros for the framed word packet parser
`ifndef FRAMED_WORD_PACKET_PARSER_DEFINES_SVH
`define FRAMED_WORD_PACKET_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FWPP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FWPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fwpp_pkg.sv */
package fwpp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned PAYLOAD_LEN = 24;
    localparam int unsigned WORD_COUNT  = 6;
    localparam int unsigned BYTES_WORD  = WORD_W / BYTE_W;
    localparam int unsigned INDEX_W     = $clog2(PAYLOAD_LEN);

    localparam logic [BYTE_W-1:0] HDR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] HDR_LF = 8'h0A;

    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_HUNT_CR   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR_LF    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TRAIL_LF  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TRAIL_CR  = 3'd4;

    typedef struct packed {
        logic                 shift;    // move the accepted byte into the cell chain
        logic                 emit;     // closing cr accepted, capture a result
        logic                 at_close; // next byte may complete a frame
        logic [PHASE_W-1:0]   phase;
    } t_ctrl;

endpackage

/* sv/fwpp_cell.sv */
module fwpp_cell
    import fwpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0] o_byte
);

    logic [BYTE_W-1:0] r_byte;

    // payload byte, handed to the lower neighbour on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

/* sv/fwpp_ctrl.sv */
module fwpp_ctrl
    import fwpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    output t_ctrl             o_ctrl
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [INDEX_W-1:0] r_index, n_index;
    logic               w_emit;

    always_comb begin
        n_phase = r_phase;
        n_index = r_index;
        w_emit  = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT_CR: begin
                    n_phase = (i_byte == HDR_CR) ? PH_HDR_LF : PH_HUNT_CR;
                end
                PH_HDR_LF: begin
                    if (i_byte == HDR_LF) begin
                        n_phase = PH_PAYLOAD;
                        n_index = '0;
                    end else if (i_byte != HDR_CR) begin
                        n_phase = PH_HUNT_CR;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_index == INDEX_W'(PAYLOAD_LEN - 1)) begin
                        n_index = '0;
                        n_phase = PH_TRAIL_LF;
                    end else begin
                        n_index = r_index + INDEX_W'(1);
                    end
                end
                PH_TRAIL_LF: begin
                    n_phase = (i_byte == HDR_LF) ? PH_TRAIL_CR : PH_HUNT_CR;
                end
                PH_TRAIL_CR: begin
                    w_emit  = (i_byte == HDR_CR);
                    n_phase = PH_HUNT_CR;
                end
                default: begin
                    n_phase = PH_HUNT_CR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT_CR;
            r_index <= '0;
        end else begin
            r_phase <= n_phase;
            r_index <= n_index;
        end
    end

    assign o_ctrl.shift    = i_accept && (r_phase == PH_PAYLOAD);
    assign o_ctrl.emit     = w_emit;
    assign o_ctrl.at_close = (r_phase == PH_TRAIL_CR);
    assign o_ctrl.phase    = r_phase;

endmodule

/* sv/framed_word_packet_parser.sv */
// framed word packet parser
// input channel: one received byte per transfer on i_rx_byte, i_rx_valid / o_rx_ready
// output channel: six signed 32-bit words per transfer, o_res_valid / i_res_ready
// frame layout: cr lf, 24 payload bytes, lf cr; words are built little-endian
// from payload bytes 0..3, 4..7 and so on up to 20..23
// one byte is taken every cycle unless o_rx_ready is low; payload bytes walk
// down a chain of 24 byte cells, so after the last payload byte cell k holds payload byte k
// the result appears in the cycle after the closing cr transfer and
// sits in the output register until it is taken
// o_rx_ready drops only when the parser waits for the closing cr while an
// earlier result is still held and not taken this cycle; any other byte is
// taken even under a stalled receiver
// a trailer mismatch sends the parser back to header hunting with no result
// reset (synchronous, active low) returns to header hunting and empties the
// output register; payload cells are not cleared, every result is built
// from a complete set of 24 fresh bytes
`include "framed_word_packet_parser_defines.svh"

module framed_word_packet_parser
    import fwpp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rx_valid,
    output logic                     o_rx_ready,
    input  logic [BYTE_W-1:0]        i_rx_byte,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic signed [WORD_W-1:0] o_line_offset,
    output logic signed [WORD_W-1:0] o_line_angle,
    output logic signed [WORD_W-1:0] o_cross_x,
    output logic signed [WORD_W-1:0] o_cross_y,
    output logic signed [WORD_W-1:0] o_image_width,
    output logic signed [WORD_W-1:0] o_image_height
);

    logic              w_accept;
    logic              w_res_take;
    t_ctrl             w_ctrl;
    logic [BYTE_W-1:0] w_cell [PAYLOAD_LEN];
    logic [WORD_W-1:0] w_word [WORD_COUNT];
    logic [WORD_W-1:0] r_word [WORD_COUNT];
    logic              r_res_valid;

    assign w_res_take = r_res_valid && i_res_ready;
    // hold input only when a completing byte could meet a full output register
    assign o_rx_ready = !(w_ctrl.at_close && r_res_valid && !i_res_ready);
    assign w_accept   = i_rx_valid && o_rx_ready;

    fwpp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_rx_byte),
        .o_ctrl   (w_ctrl)
    );

    // cell chain: new bytes enter at the top and move one cell down per shift
    for (genvar k = 0; k < PAYLOAD_LEN; k++) begin : g_cell
        logic [BYTE_W-1:0] w_in;
        if (k == PAYLOAD_LEN - 1) begin : g_top
            assign w_in = i_rx_byte;
        end else begin : g_mid
            assign w_in = w_cell[k+1];
        end
        fwpp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_ctrl.shift),
            .i_byte  (w_in),
            .o_byte  (w_cell[k])
        );
    end

    // little-endian word assembly straight from the cells
    for (genvar w = 0; w < WORD_COUNT; w++) begin : g_word
        for (genvar b = 0; b < BYTES_WORD; b++) begin : g_byte
            assign w_word[w][b*BYTE_W +: BYTE_W] = w_cell[w*BYTES_WORD + b];
        end
    end

    // output register, payload words carry no reset
    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_word <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_res_valid <= 1'b1;
        end else if (w_res_take) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_line_offset  = r_word[0];
    assign o_line_angle   = r_word[1];
    assign o_cross_x      = r_word[2];
    assign o_cross_y      = r_word[3];
    assign o_image_width  = r_word[4];
    assign o_image_height = r_word[5];

    // a stalled input always means a held, untaken result
    `FWPP_ASSERT_SAME(a_stall_cause, !o_rx_ready, o_res_valid && !i_res_ready, "input stalled without a held result")
    // a completed frame shows up as a result on the next cycle
    `FWPP_ASSERT_NEXT(a_emit_valid, w_ctrl.emit, o_res_valid, "result missing after closing byte")
    // after a completed frame the parser hunts for a new header
    `FWPP_ASSERT_NEXT(a_emit_hunt, w_ctrl.emit, w_ctrl.phase == PH_HUNT_CR, "parser not hunting after frame")
    // a result can only come from the closing-cr phase
    `FWPP_ASSERT_SAME(a_emit_phase, w_ctrl.emit, w_ctrl.phase == PH_TRAIL_CR && w_accept, "result outside closing phase")

endmodule

/* test/tb_framed_word_packet_parser.sv */
module tb_framed_word_packet_parser
    import fwpp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // stimulus sizing
    localparam int ITEM_TARGET  = 1550;  // bytes to queue before the run starts
    localparam int TAIL_ITEMS   = 150;   // last stretch of the run runs without idling
    localparam int HOLD_AT      = 300;   // transfers taken before the long receiver hold
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    // how a queued frame is spoilt, if at all
    typedef enum {FRAME_WHOLE, FRAME_BAD_HDR, FRAME_BAD_LF, FRAME_BAD_CR} t_frame_flaw;

    // one result transfer: six little-endian words
    typedef struct packed {
        logic signed [WORD_W-1:0] line_offset;
        logic signed [WORD_W-1:0] line_angle;
        logic signed [WORD_W-1:0] cross_x;
        logic signed [WORD_W-1:0] cross_y;
        logic signed [WORD_W-1:0] image_width;
        logic signed [WORD_W-1:0] image_height;
    } t_frame_words;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     rx_valid  = 1'b0;
    logic                     rx_ready;
    logic [BYTE_W-1:0]        rx_byte   = '0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    logic signed [WORD_W-1:0] line_offset;
    logic signed [WORD_W-1:0] line_angle;
    logic signed [WORD_W-1:0] cross_x;
    logic signed [WORD_W-1:0] cross_y;
    logic signed [WORD_W-1:0] image_width;
    logic signed [WORD_W-1:0] image_height;

    // bytes waiting to be offered, words waiting to come out
    logic [BYTE_W-1:0] byte_queue[$];
    t_frame_words      expected_words[$];

    // deframer mirror
    logic [PHASE_W-1:0] parse_phase = PH_HUNT_CR;
    int unsigned        slot_index  = 0;
    logic [BYTE_W-1:0]  payload_bytes[PAYLOAD_LEN];

    // idling and pressure control
    int  send_gap = 0;
    int  take_gap = 0;
    bit  rx_hold  = 1'b0;

    // bookkeeping
    int errors        = 0;
    int bytes_taken   = 0;
    int frames_seen   = 0;
    int frames_whole  = 0;
    int frames_broken = 0;
    int input_stalls  = 0;

    always #10 clk = ~clk;

    framed_word_packet_parser i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_line_offset  (line_offset),
        .o_line_angle   (line_angle),
        .o_cross_x      (cross_x),
        .o_cross_y      (cross_y),
        .o_image_width  (image_width),
        .o_image_height (image_height)
    );

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // the closing part of the run has no idling on either side
    function automatic bit in_tail();
        return byte_queue.size() < TAIL_ITEMS;
    endfunction

    // little-endian word k from the mirrored payload
    function automatic logic [WORD_W-1:0] payload_word(input int k);
        return {payload_bytes[4*k+3], payload_bytes[4*k+2],
                payload_bytes[4*k+1], payload_bytes[4*k]};
    endfunction

    // advance the mirrored deframer by one accepted byte
    function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
        t_frame_words w;
        case (parse_phase)
            PH_HUNT_CR: begin
                parse_phase = (b == HDR_CR) ? PH_HDR_LF : PH_HUNT_CR;
            end
            PH_HDR_LF: begin
                // a repeated cr keeps waiting for the lf
                if (b == HDR_LF) begin
                    parse_phase = PH_PAYLOAD;
                    slot_index  = 0;
                end else if (b != HDR_CR) begin
                    parse_phase = PH_HUNT_CR;
                end
            end
            PH_PAYLOAD: begin
                payload_bytes[slot_index] = b;
                if (slot_index == PAYLOAD_LEN - 1) begin
                    slot_index  = 0;
                    parse_phase = PH_TRAIL_LF;
                end else begin
                    slot_index++;
                end
            end
            PH_TRAIL_LF: begin
                parse_phase = (b == HDR_LF) ? PH_TRAIL_CR : PH_HUNT_CR;
            end
            PH_TRAIL_CR: begin
                // back to hunting whether or not the closing cr matched
                if (b == HDR_CR) begin
                    w.line_offset  = payload_word(0);
                    w.line_angle   = payload_word(1);
                    w.cross_x      = payload_word(2);
                    w.cross_y      = payload_word(3);
                    w.image_width  = payload_word(4);
                    w.image_height = payload_word(5);
                    expected_words.push_back(w);
                end
                parse_phase = PH_HUNT_CR;
            end
            default: begin
                parse_phase = PH_HUNT_CR;
            end
        endcase
    endfunction

    // payload bytes lean towards the framing bytes and the extremes
    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return HDR_CR;
            1:       return HDR_LF;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // any byte except the one given
    function automatic logic [BYTE_W-1:0] other_byte(input logic [BYTE_W-1:0] avoid);
        logic [BYTE_W-1:0] b;
        do begin
            b = BYTE_W'($urandom_range(0, 255));
        end while (b == avoid);
        return b;
    endfunction

    // queue one frame with random payload, possibly spoilt
    task automatic queue_frame(input t_frame_flaw flaw);
        logic [BYTE_W-1:0] b;
        byte_queue.push_back(HDR_CR);
        if (flaw == FRAME_BAD_HDR) begin
            do begin
                b = BYTE_W'($urandom_range(0, 255));
            end while (b == HDR_LF || b == HDR_CR);
            byte_queue.push_back(b);
            frames_broken++;
            return;
        end
        // sometimes a run of extra cr before the lf
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) byte_queue.push_back(HDR_CR);
        end
        byte_queue.push_back(HDR_LF);
        repeat (PAYLOAD_LEN) byte_queue.push_back(payload_byte());
        if (flaw == FRAME_BAD_LF) begin
            byte_queue.push_back(other_byte(HDR_LF));
            frames_broken++;
        end else if (flaw == FRAME_BAD_CR) begin
            byte_queue.push_back(HDR_LF);
            byte_queue.push_back(other_byte(HDR_CR));
            frames_broken++;
        end else begin
            byte_queue.push_back(HDR_LF);
            byte_queue.push_back(HDR_CR);
            frames_whole++;
        end
    endtask

    // sender: offers queued bytes, idles in bursts, mirrors every transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid    <= 1'b0;
            send_gap    <= 0;
            parse_phase = PH_HUNT_CR;
            slot_index  = 0;
        end else begin
            if (rx_valid && rx_ready) begin
                absorb_byte(rx_byte);
                bytes_taken++;
            end
            if (rx_valid && !rx_ready) begin
                // held off by the parser, keep the byte steady
                input_stalls++;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                rx_valid <= 1'b0;
            end else if (byte_queue.size() == 0) begin
                rx_valid <= 1'b0;
            end else if (!in_tail() && !rx_hold && $urandom_range(0, 9) == 0) begin
                // start an idle gap; send_gap counts down its remaining length
                send_gap <= $urandom_range(0, 13);
                rx_valid <= 1'b0;
            end else begin
                rx_valid <= 1'b1;
                rx_byte  <= byte_queue.pop_front();
            end
        end
    end

    // receiver: takes results, stalls in bursts, checks against the oldest expectation
    always @(posedge clk) begin
        t_frame_words got;
        t_frame_words want;
        if (!rst_n) begin
            res_ready <= 1'b0;
            take_gap  <= 0;
        end else begin
            if (res_valid && res_ready) begin
                got = {line_offset, line_angle, cross_x, cross_y,
                       image_width, image_height};
                frames_seen++;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result transfer with none expected: %h", got));
                end else begin
                    want = expected_words.pop_front();
                    if (got.line_offset !== want.line_offset)
                        report_mismatch($sformatf("line_offset got %h expected %h",
                                                  got.line_offset, want.line_offset));
                    if (got.line_angle !== want.line_angle)
                        report_mismatch($sformatf("line_angle got %h expected %h",
                                                  got.line_angle, want.line_angle));
                    if (got.cross_x !== want.cross_x)
                        report_mismatch($sformatf("cross_x got %h expected %h",
                                                  got.cross_x, want.cross_x));
                    if (got.cross_y !== want.cross_y)
                        report_mismatch($sformatf("cross_y got %h expected %h",
                                                  got.cross_y, want.cross_y));
                    if (got.image_width !== want.image_width)
                        report_mismatch($sformatf("image_width got %h expected %h",
                                                  got.image_width, want.image_width));
                    if (got.image_height !== want.image_height)
                        report_mismatch($sformatf("image_height got %h expected %h",
                                                  got.image_height, want.image_height));
                end
            end
            if (rx_hold) begin
                res_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap  <= take_gap - 1;
                res_ready <= 1'b0;
            end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
                take_gap  <= $urandom_range(0, 13);
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // long receiver hold so that a held result blocks the next closing cr
    initial begin
        while (bytes_taken < HOLD_AT) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // overall time limit
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int pick;
        // stray bytes while hunting, then a header mismatch
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(HDR_LF);
        byte_queue.push_back(HDR_CR);
        byte_queue.push_back(8'h55);
        // repeated cr in the header, then a frame with extreme words:
        // most negative, most positive, all ones, zero, framing bytes inside
        // the payload, and a plain pattern
        byte_queue.push_back(HDR_CR);
        byte_queue.push_back(HDR_CR);
        byte_queue.push_back(HDR_CR);
        byte_queue.push_back(HDR_LF);
        byte_queue.push_back(8'h00); byte_queue.push_back(8'h00);
        byte_queue.push_back(8'h00); byte_queue.push_back(8'h80);
        byte_queue.push_back(8'hFF); byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'hFF); byte_queue.push_back(8'h7F);
        repeat (4) byte_queue.push_back(8'hFF);
        repeat (4) byte_queue.push_back(8'h00);
        byte_queue.push_back(HDR_CR); byte_queue.push_back(HDR_LF);
        byte_queue.push_back(HDR_LF); byte_queue.push_back(HDR_CR);
        byte_queue.push_back(8'h78); byte_queue.push_back(8'h56);
        byte_queue.push_back(8'h34); byte_queue.push_back(8'h12);
        byte_queue.push_back(HDR_LF);
        byte_queue.push_back(HDR_CR);
        frames_whole++;

        // random part: mostly whole frames, some broken ones and line noise
        while (byte_queue.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                queue_frame(FRAME_WHOLE);
            end else if (pick == 14) begin
                queue_frame(FRAME_BAD_HDR);
            end else if (pick == 15) begin
                queue_frame(FRAME_BAD_LF);
            end else if (pick == 16) begin
                queue_frame(FRAME_BAD_CR);
            end else begin
                repeat ($urandom_range(1, 6)) byte_queue.push_back(payload_byte());
            end
        end
        // the final frame is whole so the run ends on a result
        queue_frame(FRAME_WHOLE);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || rx_valid) @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes sent: %0d whole frames, %0d broken frames, plus line noise",
                 bytes_taken, frames_whole, frames_broken);
        $display("%0d results checked, input held off by the parser for %0d cycles",
                 frames_seen, input_stalls);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
